@@ hw/rtl/reog_pkg.sv @@
// Shared types, constants and CORDIC helper functions for the rotated ellipse outline generator.
// No dependencies; reog_front, reog_queue, reog_back and the top level import this package.
package reog_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [6:0] VC_RESET = 7'd36;
    localparam logic [6:0] VC_MIN = 7'd3;
    localparam logic [16:0] ELONG_ONE = 17'd65536;

    typedef enum logic [1:0] {
        F_IDLE,
        F_RUN,
        F_PUSH
    } reog_fstate_t;

    // CORDIC working vector: Q2.30 x and y, angle z in 1/2^32 turn.
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [33:0] z;
    } reog_cvec_t;

    // Quadrant fixup carried alongside the CORDIC vector.
    typedef struct packed {
        logic              neg;
        logic              exact;
        logic signed [31:0] ec;
        logic signed [31:0] es;
    } reog_cfix_t;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
    } reog_trig_t;

    // Per-ellipse geometry needed by the vertex datapath.
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        r;
        logic [46:0]        lng;
        logic signed [31:0] ct;
        logic signed [31:0] st;
    } reog_geom_t;

    // One queue entry handed from the front end to the back end.
    typedef struct packed {
        reog_geom_t  geom;
        logic [31:0] step_q;
        logic [6:0]  step_r;
        logic [6:0]  n;
        logic        bad;
    } reog_job_t;

    // Per-beat tag that travels with a vertex through the pipeline.
    typedef struct packed {
        logic       bad;
        logic [5:0] idx;
        logic       last;
    } reog_tag_t;

    function automatic logic [29:0] atan_turn(input logic [4:0] k);
        logic [29:0] v;
        unique case (k)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Fold the angle into [-1/4, 1/4) turn and build the start vector.
    function automatic reog_cvec_t cordic_init(input logic [31:0] ang);
        logic [31:0] a;
        reog_cvec_t  v;
        a = ang;
        if (ang[31] ^ ang[30]) begin
            a = {~ang[31], ang[30:0]};
        end
        v.x = CORDIC_START;
        v.y = '0;
        v.z = $signed({{2{a[31]}}, a});
        return v;
    endfunction

    // Exact quarter-turn results and the sign flip for the folded half.
    function automatic reog_cfix_t cordic_fix(input logic [31:0] ang);
        reog_cfix_t f;
        f.neg   = ang[31] ^ ang[30];
        f.exact = (ang[29:0] == 30'd0);
        unique case (ang[31:30])
            2'b00: begin
                f.ec = ONE_Q30;
                f.es = '0;
            end
            2'b01: begin
                f.ec = '0;
                f.es = ONE_Q30;
            end
            2'b10: begin
                f.ec = -ONE_Q30;
                f.es = '0;
            end
            default: begin
                f.ec = '0;
                f.es = -ONE_Q30;
            end
        endcase
        return f;
    endfunction

    function automatic reog_cvec_t cordic_step(input reog_cvec_t v, input logic [4:0] k);
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        logic signed [33:0] at;
        reog_cvec_t         n;
        xs = $signed(v.x) >>> k;
        ys = $signed(v.y) >>> k;
        at = $signed({4'b0000, atan_turn(k)});
        if (!v.z[33]) begin
            n.x = v.x - ys;
            n.y = v.y + xs;
            n.z = v.z - at;
        end else begin
            n.x = v.x + ys;
            n.y = v.y - xs;
            n.z = v.z + at;
        end
        return n;
    endfunction

    function automatic reog_trig_t cordic_finish(input reog_cvec_t v, input reog_cfix_t f);
        logic signed [32:0] nx;
        logic signed [32:0] ny;
        reog_trig_t         t;
        nx = -v.x;
        ny = -v.y;
        if (f.exact) begin
            t.c = f.ec;
            t.s = f.es;
        end else if (f.neg) begin
            t.c = nx[31:0];
            t.s = ny[31:0];
        end else begin
            t.c = v.x[31:0];
            t.s = v.y[31:0];
        end
        return t;
    endfunction

endpackage

@@ hw/rtl/reog_div.sv @@
// Restoring unsigned divider, two quotient bits per cycle, quotient and remainder out.
// Depends on nothing; used by reog_front.
module reog_div #(
    parameter int DW = 48,
    parameter int VW = 17
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);
    localparam int STEPS = DW / 2;
    localparam int CW = $clog2(STEPS + 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dq_reg, dq_next;
    logic [VW-1:0] div_reg, div_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [VW:0]   trial;
    logic          ge;

    always_comb begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = '0;
        ge        = 1'b0;
        if (start) begin
            rem_next  = '0;
            dq_next   = dividend;
            div_next  = divisor;
            cnt_next  = CW'(STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int j = 0; j < 2; j++) begin
                trial = {rem_next, dq_next[DW-1]};
                ge    = (trial >= {1'b0, div_reg});
                if (ge) begin
                    trial = trial - {1'b0, div_reg};
                end
                rem_next = trial[VW-1:0];
                dq_next  = {dq_next[DW-2:0], ge};
            end
            cnt_next  = cnt_reg - CW'(1);
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        div_reg <= div_next;
    end

    assign busy      = busy_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/reog_front.sv @@
// Front end: takes ellipse beats, checks them, computes the long radius, the rotation
// sine/cosine and the per-vertex angle step, then pushes one job. Uses reog_pkg, reog_div.
module reog_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_center_x,
    input  logic signed [31:0]  s_center_y,
    input  logic [30:0]         s_short_radius,
    input  logic [16:0]         s_elongation,
    input  logic [15:0]         s_rotation,
    input  logic [6:0]          n_eff,
    input  logic                q_full,
    output logic                q_push,
    output reog_pkg::reog_job_t q_data
);
    import reog_pkg::*;

    // One-beat input buffer so a new ellipse can land while the engine works.
    logic               in_vld_reg, in_vld_next;
    logic signed [31:0] in_cx_reg, in_cy_reg;
    logic [30:0]        in_r_reg;
    logic [16:0]        in_e_reg;
    logic [15:0]        in_rot_reg;
    logic [6:0]         in_n_reg;

    reog_fstate_t state_reg, state_next;
    logic         take, div_start, step_en;

    logic signed [31:0] cx_reg, cy_reg;
    logic [30:0]        r_reg;
    logic [6:0]         n_reg;
    logic               bad_reg;
    reog_cvec_t         cv_reg, cv_next;
    reog_cfix_t         fix_reg;
    logic [4:0]         k_reg, k_next;

    logic        bad_in;
    logic [16:0] e_clamp;
    logic [31:0] rot_ang;
    logic        lbusy, nbusy;
    logic [47:0] lquot;
    logic [16:0] lrem;
    logic [33:0] nquot;
    logic [6:0]  nrem;
    logic        run_done;

    assign s_ready  = !in_vld_reg;
    assign bad_in   = (in_r_reg == 31'd0) || (in_e_reg == 17'd0);
    assign e_clamp  = (in_e_reg > ELONG_ONE) ? ELONG_ONE : in_e_reg;
    assign rot_ang  = 32'd0 - {in_rot_reg, 16'h0000};
    assign run_done = (k_reg == 5'(CORDIC_STEPS)) && !lbusy && !nbusy;

    reog_div #(.DW(48), .VW(17)) u_lng_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  ({1'b0, in_r_reg, 16'h0000}),
        .divisor   (e_clamp),
        .busy      (lbusy),
        .quotient  (lquot),
        .remainder (lrem)
    );

    reog_div #(.DW(34), .VW(7)) u_step_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  ({2'b01, 32'h0000_0000}),
        .divisor   (in_n_reg),
        .busy      (nbusy),
        .quotient  (nquot),
        .remainder (nrem)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (in_vld_reg) begin
                    state_next = bad_in ? F_PUSH : F_RUN;
                end
            end
            F_RUN: begin
                if (run_done) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        take      = 1'b0;
        div_start = 1'b0;
        step_en   = 1'b0;
        q_push    = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                take      = in_vld_reg;
                div_start = in_vld_reg && !bad_in;
            end
            F_RUN:  step_en = (k_reg != 5'(CORDIC_STEPS));
            F_PUSH: q_push = !q_full;
            default: ;
        endcase
    end

    always_comb begin
        in_vld_next = in_vld_reg;
        if (take) begin
            in_vld_next = 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end
    end

    always_comb begin
        cv_next = cv_reg;
        k_next  = k_reg;
        if (take) begin
            cv_next = cordic_init(rot_ang);
            k_next  = '0;
        end else if (step_en) begin
            cv_next = cordic_step(cv_reg, k_reg);
            k_next  = k_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            in_vld_reg <= 1'b0;
            k_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            in_vld_reg <= in_vld_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cx_reg  <= s_center_x;
            in_cy_reg  <= s_center_y;
            in_r_reg   <= s_short_radius;
            in_e_reg   <= s_elongation;
            in_rot_reg <= s_rotation;
            in_n_reg   <= n_eff;
        end
        if (take) begin
            cx_reg  <= in_cx_reg;
            cy_reg  <= in_cy_reg;
            r_reg   <= in_r_reg;
            n_reg   <= in_n_reg;
            bad_reg <= bad_in;
            fix_reg <= cordic_fix(rot_ang);
        end
        cv_reg <= cv_next;
    end

    always_comb begin
        reog_trig_t rt;
        rt = cordic_finish(cv_reg, fix_reg);
        q_data.geom.cx  = cx_reg;
        q_data.geom.cy  = cy_reg;
        q_data.geom.r   = r_reg;
        q_data.geom.lng = lquot[46:0];
        q_data.geom.ct  = rt.c;
        q_data.geom.st  = rt.s;
        q_data.step_q   = nquot[31:0];
        q_data.step_r   = nrem;
        q_data.n        = n_reg;
        q_data.bad      = bad_reg;
    end

    // A job leaves only after the rotation iterations finished, unless it is a bad shape.
    a_push_done: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (bad_reg || (k_reg == 5'(CORDIC_STEPS) && !lbusy && !nbusy)))
        else $error("front pushed an unfinished job");

endmodule

@@ hw/rtl/reog_queue.sv @@
// Two-entry job queue between the front end and the vertex back end.
// Uses reog_pkg for the job type and depth.
module reog_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  reog_pkg::reog_job_t wdata,
    output logic                full,
    input  logic                pop,
    output reog_pkg::reog_job_t rdata,
    output logic                empty
);
    import reog_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    reog_job_t     mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("job queue read while empty");

endmodule

@@ hw/rtl/reog_back.sv @@
// Back end: steps through the vertices of each job and runs them down a pipelined
// CORDIC, the rotation multiplies and the saturating adds. Uses reog_pkg.
module reog_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    output logic                q_pop,
    input  reog_pkg::reog_job_t q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_vertex_x,
    output logic signed [31:0]  m_vertex_y,
    output logic [5:0]          m_vertex_index,
    output logic                m_last_vertex,
    output logic                m_bad_shape
);
    import reog_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -52'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic en;

    // Vertex sequencer.
    logic        act_reg, act_next;
    reog_job_t   cur_reg;
    logic [5:0]  i_reg, i_next;
    logic [31:0] t_reg, t_next;
    logic [6:0]  rem_reg, rem_next;
    logic [7:0]  rem_sum;
    logic        wrap, last_now, issue;

    // CORDIC pipeline, stage 0 is the folded start vector.
    reog_cvec_t cv_reg  [0:CORDIC_STEPS];
    reog_cfix_t fix_reg [0:CORDIC_STEPS];
    reog_geom_t geo_reg [0:CORDIC_STEPS];
    reog_tag_t  tag_reg [0:CORDIC_STEPS];
    logic       vld_reg [0:CORDIC_STEPS];

    // Tail stages: trig, first products, local point, second products, rotated terms.
    reog_trig_t         trig_reg;
    reog_geom_t         geo_t_reg, geo_1_reg, geo_2_reg, geo_3_reg, geo_4_reg;
    reog_tag_t          tag_t_reg, tag_1_reg, tag_2_reg, tag_3_reg, tag_4_reg;
    logic               vld_t_reg, vld_1_reg, vld_2_reg, vld_3_reg, vld_4_reg;
    logic signed [63:0] p1_reg, p2_reg;
    logic signed [48:0] q1_reg;
    logic signed [48:0] xx_reg;
    logic signed [32:0] yy_reg;
    logic signed [64:0] pa_h_reg, pc_h_reg, pb_reg, pd_reg;
    logic signed [48:0] pa_l_reg, pc_l_reg;
    logic signed [49:0] ta_reg, tb_reg, tc_reg, td_reg;

    logic               m_valid_reg;
    logic signed [31:0] m_x_reg, m_y_reg;
    logic [5:0]         m_idx_reg;
    logic               m_last_reg, m_bad_reg;

    assign en = !m_valid_reg || m_ready;

    assign last_now = cur_reg.bad || ({1'b0, i_reg} == (cur_reg.n - 7'd1));
    assign issue    = act_reg && en;
    assign q_pop    = !q_empty && (!act_reg || (issue && last_now));
    assign rem_sum  = {1'b0, rem_reg} + {1'b0, cur_reg.step_r};
    assign wrap     = (rem_sum >= {1'b0, cur_reg.n});

    always_comb begin
        act_next = act_reg;
        i_next   = i_reg;
        t_next   = t_reg;
        rem_next = rem_reg;
        if (q_pop) begin
            act_next = 1'b1;
            i_next   = '0;
            t_next   = '0;
            rem_next = '0;
        end else if (issue) begin
            if (last_now) begin
                act_next = 1'b0;
            end else begin
                i_next   = i_reg + 6'd1;
                rem_next = wrap ? 7'(rem_sum - {1'b0, cur_reg.n}) : rem_sum[6:0];
                t_next   = t_reg + cur_reg.step_q + {31'd0, wrap};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
        end else begin
            act_reg <= act_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        i_reg   <= i_next;
        t_reg   <= t_next;
        rem_reg <= rem_next;
    end

    // Stage 0: fold the vertex angle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cv_reg[0]       <= cordic_init(t_reg);
            fix_reg[0]      <= cordic_fix(t_reg);
            geo_reg[0]      <= cur_reg.geom;
            tag_reg[0].bad  <= cur_reg.bad;
            tag_reg[0].idx  <= cur_reg.bad ? 6'd0 : i_reg;
            tag_reg[0].last <= cur_reg.bad ? 1'b0 : last_now;
        end
    end

    // One CORDIC iteration per stage.
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                cv_reg[g+1]  <= cordic_step(cv_reg[g], 5'(g));
                fix_reg[g+1] <= fix_reg[g];
                geo_reg[g+1] <= geo_reg[g];
                tag_reg[g+1] <= tag_reg[g];
            end
        end
    end

    logic signed [31:0] m1_hi, m1_r;
    logic signed [16:0] m1_lo;
    logic signed [80:0] xx_sum;
    logic signed [32:0] xh;
    logic signed [16:0] xl;
    logic signed [81:0] a_sum, c_sum;
    logic signed [51:0] sx, sy;

    always_comb begin
        m1_hi  = $signed({1'b0, geo_t_reg.lng[46:16]});
        m1_lo  = $signed({1'b0, geo_t_reg.lng[15:0]});
        m1_r   = $signed({1'b0, geo_t_reg.r});
        xx_sum = (81'(p1_reg) <<< 16) + 81'(q1_reg);
        xh     = 33'(xx_reg >>> 16);
        xl     = $signed({1'b0, xx_reg[15:0]});
        a_sum  = (82'(pa_h_reg) <<< 16) + 82'(pa_l_reg);
        c_sum  = (82'(pc_h_reg) <<< 16) + 82'(pc_l_reg);
        sx     = 52'(geo_4_reg.cx) + 52'(ta_reg) - 52'(tb_reg);
        sy     = 52'(geo_4_reg.cy) + 52'(tc_reg) + 52'(td_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_t_reg   <= 1'b0;
            vld_1_reg   <= 1'b0;
            vld_2_reg   <= 1'b0;
            vld_3_reg   <= 1'b0;
            vld_4_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_t_reg   <= vld_reg[CORDIC_STEPS];
            vld_1_reg   <= vld_t_reg;
            vld_2_reg   <= vld_1_reg;
            vld_3_reg   <= vld_2_reg;
            vld_4_reg   <= vld_3_reg;
            m_valid_reg <= vld_4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg  <= cordic_finish(cv_reg[CORDIC_STEPS], fix_reg[CORDIC_STEPS]);
            geo_t_reg <= geo_reg[CORDIC_STEPS];
            tag_t_reg <= tag_reg[CORDIC_STEPS];

            p1_reg    <= m1_hi * trig_reg.c;
            q1_reg    <= m1_lo * trig_reg.c;
            p2_reg    <= m1_r * trig_reg.s;
            geo_1_reg <= geo_t_reg;
            tag_1_reg <= tag_t_reg;

            xx_reg    <= 49'(xx_sum >>> 30);
            yy_reg    <= 33'(p2_reg >>> 30);
            geo_2_reg <= geo_1_reg;
            tag_2_reg <= tag_1_reg;

            pa_h_reg  <= xh * geo_2_reg.ct;
            pa_l_reg  <= xl * geo_2_reg.ct;
            pc_h_reg  <= xh * geo_2_reg.st;
            pc_l_reg  <= xl * geo_2_reg.st;
            pb_reg    <= yy_reg * geo_2_reg.st;
            pd_reg    <= yy_reg * geo_2_reg.ct;
            geo_3_reg <= geo_2_reg;
            tag_3_reg <= tag_2_reg;

            ta_reg    <= 50'(a_sum >>> 30);
            tc_reg    <= 50'(c_sum >>> 30);
            tb_reg    <= 50'(pb_reg >>> 30);
            td_reg    <= 50'(pd_reg >>> 30);
            geo_4_reg <= geo_3_reg;
            tag_4_reg <= tag_3_reg;

            m_x_reg    <= tag_4_reg.bad ? 32'sd0 : sat32(sx);
            m_y_reg    <= tag_4_reg.bad ? 32'sd0 : sat32(sy);
            m_idx_reg  <= tag_4_reg.idx;
            m_last_reg <= tag_4_reg.last;
            m_bad_reg  <= tag_4_reg.bad;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_vertex_x     = m_x_reg;
    assign m_vertex_y     = m_y_reg;
    assign m_vertex_index = m_idx_reg;
    assign m_last_vertex  = m_last_reg;
    assign m_bad_shape    = m_bad_reg;

    a_bad_beat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_bad_reg) |-> (m_idx_reg == 6'd0 && !m_last_reg))
        else $error("bad-shape beat carries a vertex position");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (act_reg && !cur_reg.bad) |-> ({1'b0, i_reg} < cur_reg.n))
        else $error("vertex index ran past the vertex count");

    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (act_reg && !cur_reg.bad) |-> (rem_reg < cur_reg.n))
        else $error("angle step remainder out of range");

endmodule

@@ hw/rtl/rotated_ellipse_outline_generator_core.sv @@
// Top level of the rotated ellipse outline generator: configuration register,
// front end, job queue and vertex back end. Uses reog_pkg, reog_front, reog_queue, reog_back.
//
// Usage. Each beat on the s_ channel describes one ellipse (center, short radius,
// elongation, rotation). The m_ channel returns the outline as one beat per vertex,
// vertex 0 first, with m_last_vertex on the final one; the closing edge runs back to
// vertex 0. An ellipse with zero radius or zero elongation yields a single beat with
// m_bad_shape set and all other fields zero. The cfg_ channel writes the vertex count
// (clamped to 3..MAX_VERTICES); write it only while no ellipse is in flight.
// Timing. For a valid ellipse the front end takes the beat, runs the 30-iteration rotation
// CORDIC (the dividers finish earlier), checks that all are done and pushes the job; a bad
// shape goes from take straight to push. The back end issues one vertex per cycle, while
// m_ready allows, into a 37-stage pipeline (30 CORDIC stages plus multiply and saturate
// stages).
// A two-entry job queue lets the front end prepare the next ellipse while the back
// end is still emitting. When m_ready is low with an output beat waiting, the whole back
// pipeline holds; the input side keeps accepting until its buffer and the queue fill.
// Reset. aresetn is synchronous and active low; it empties all buffers and restores
// the vertex count to 36.
module rotated_ellipse_outline_generator_core #(
    parameter int MAX_VERTICES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_center_x,
    input  logic signed [31:0] s_center_y,
    input  logic [30:0]        s_short_radius,
    input  logic [16:0]        s_elongation,
    input  logic [15:0]        s_rotation,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_vertex_x,
    output logic signed [31:0] m_vertex_y,
    output logic [5:0]         m_vertex_index,
    output logic               m_last_vertex,
    output logic               m_bad_shape
);
    import reog_pkg::*;

    logic [6:0] vc_reg, vc_next;
    logic [6:0] n_eff;
    logic       q_push, q_pop, q_full, q_empty;
    reog_job_t  q_wdata, q_rdata;

    // The register is always writable.
    assign cfg_ready = 1'b1;

    always_comb begin
        vc_next = vc_reg;
        if (cfg_valid && cfg_ready) begin
            vc_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= VC_RESET;
        end else begin
            vc_reg <= vc_next;
        end
    end

    // Effective count, sampled with each ellipse as it enters.
    always_comb begin
        if (vc_reg < VC_MIN) begin
            n_eff = VC_MIN;
        end else if (vc_reg > 7'(MAX_VERTICES)) begin
            n_eff = 7'(MAX_VERTICES);
        end else begin
            n_eff = vc_reg;
        end
    end

    reog_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_short_radius (s_short_radius),
        .s_elongation   (s_elongation),
        .s_rotation     (s_rotation),
        .n_eff          (n_eff),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_wdata)
    );

    reog_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    reog_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .q_data         (q_rdata),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_vertex_x     (m_vertex_x),
        .m_vertex_y     (m_vertex_y),
        .m_vertex_index (m_vertex_index),
        .m_last_vertex  (m_last_vertex),
        .m_bad_shape    (m_bad_shape)
    );

endmodule
